FILE: src/srt_pkg.sv
// srt_pkg: shared types, codes and helpers for the sorted record table
// record and token layouts, command and status codes, key comparison
// no dependencies
`default_nettype none

package srt_pkg;

  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_NAME_BYTES  = 16;
  localparam int NAME_SPAN       = 16;  // bytes carried by name_high and name_low
  localparam int POS_W           = 8;   // covers table depths up to 256
  localparam int ID_W            = 5;
  localparam int VAL_W           = 64;

  // command codes
  localparam logic [2:0] CMD_INSERT    = 3'd0;
  localparam logic [2:0] CMD_FIND_OBJ  = 3'd1;
  localparam logic [2:0] CMD_FIND_NAME = 3'd2;
  localparam logic [2:0] CMD_FIND_TIME = 3'd3;
  localparam logic [2:0] CMD_READ      = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // sort keys
  localparam logic [1:0] KEY_TIME = 2'd0;
  localparam logic [1:0] KEY_OBJ  = 2'd1;
  localparam logic [1:0] KEY_NAME = 2'd2;

  // register indexes
  localparam logic REG_SORT_KEY   = 1'b0;
  localparam logic REG_SORT_ORDER = 1'b1;

  typedef enum logic [2:0] {
    OP_INSERT,
    OP_FIND_OBJ,
    OP_FIND_NAME,
    OP_FIND_TIME,
    OP_READ,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [VAL_W-1:0] name_high;
    logic [VAL_W-1:0] name_low;
    logic [VAL_W-1:0] object_number;
    logic [VAL_W-1:0] time_value;
    logic             active;
    logic [ID_W-1:0]  record_id;
  } rec_t;

  typedef struct packed {
    op_t              op;
    logic             flag;   // hit for searches, placed for inserts
    logic [POS_W-1:0] pos;
    rec_t             rec;
  } tok_t;

  typedef struct packed {
    logic [1:0] sort_key;
    logic       sort_order;
  } cfg_t;

  // true when stored record s sorts strictly after new record n
  function automatic logic rec_later(rec_t s, rec_t n, cfg_t c);
    logic gt;
    logic lt;
    case (c.sort_key)
      KEY_OBJ: begin
        gt = s.object_number > n.object_number;
        lt = s.object_number < n.object_number;
      end
      KEY_NAME: begin
        gt = {s.name_high, s.name_low} > {n.name_high, n.name_low};
        lt = {s.name_high, s.name_low} < {n.name_high, n.name_low};
      end
      default: begin
        gt = s.time_value > n.time_value;
        lt = s.time_value < n.time_value;
      end
    endcase
    return c.sort_order ? lt : gt;
  endfunction

endpackage

`default_nettype wire

FILE: src/srt_regs.sv
// srt_regs: configuration registers behind the apb-style port
// holds sort key and sort order; uses srt_pkg
`default_nettype none

module srt_regs
  import srt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SORT_KEY:   cfg.sort_key   <= pwdata[1:0];
        REG_SORT_ORDER: cfg.sort_order <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SORT_KEY:   prdata = {30'b0, cfg.sort_key};
      REG_SORT_ORDER: prdata = {31'b0, cfg.sort_order};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/srt_cell.sv
// srt_cell: one slot of the record chain
// keeps one record and passes the command token to the next slot; uses srt_pkg
`default_nettype none

module srt_cell
  import srt_pkg::*;
#(
  parameter int INDEX  = 0,
  parameter int FILL_W = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic [FILL_W-1:0] fill_count,
  input  wire logic              in_valid,
  input  wire tok_t              in_tok,
  output logic                   out_valid,
  output tok_t                   out_tok
);

  rec_t             rec;
  rec_t             rec_next;
  tok_t             tok_next;
  logic             live;
  logic             at_end;
  logic             hit;
  logic [POS_W-1:0] here;

  assign live   = FILL_W'(INDEX) < fill_count;
  assign at_end = FILL_W'(INDEX) == fill_count;
  assign here   = POS_W'(INDEX);

  always_comb begin
    rec_next = rec;
    tok_next = in_tok;
    hit      = 1'b0;
    case (in_tok.op)
      OP_INSERT: begin
        if (live) begin
          // once placed, every later slot shifts down by one
          if (in_tok.flag) begin
            rec_next     = in_tok.rec;
            tok_next.rec = rec;
          end else if (rec_later(rec, in_tok.rec, cfg)) begin
            rec_next      = in_tok.rec;
            tok_next.rec  = rec;
            tok_next.flag = 1'b1;
            tok_next.pos  = here;
          end
        end else if (at_end) begin
          rec_next      = in_tok.rec;
          tok_next.flag = 1'b1;
          if (!in_tok.flag) begin
            tok_next.pos = here;
          end
        end
      end
      OP_FIND_OBJ:  hit = rec.object_number == in_tok.rec.object_number;
      OP_FIND_NAME: hit = rec.name_high == in_tok.rec.name_high &&
                          rec.name_low == in_tok.rec.name_low;
      OP_FIND_TIME: hit = rec.time_value == in_tok.rec.time_value;
      OP_READ:      hit = in_tok.pos == here;
      default: ;
    endcase
    // first match in list order wins
    if (hit && live && !in_tok.flag) begin
      tok_next.rec  = rec;
      tok_next.flag = 1'b1;
      tok_next.pos  = here;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      rec     <= rec_next;
      out_tok <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

endmodule

`default_nettype wire

FILE: src/sorted_record_table.sv
// sorted_record_table: bounded table of records kept in sorted order
// each command token walks the chain of MAX_ENTRIES slot cells, then the result strobe is raised
// one command in flight at a time; the next start is taken in the strobe cycle
// reset: synchronous; empties the table, clears sort key and order; slot contents stay undefined
// the receiver cannot stall: each result is on the ports for exactly one cycle with done
`default_nettype none

module sorted_record_table
  import srt_pkg::*;
#(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int NAME_BYTES  = DEF_NAME_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  command,
  input  wire logic [63:0] name_high,
  input  wire logic [63:0] name_low,
  input  wire logic [63:0] object_number,
  input  wire logic [63:0] time_value,
  input  wire logic        is_active,
  input  wire logic [3:0]  position,
  // result channel
  output logic             done,
  output logic      [1:0]  status,
  output logic      [4:0]  record_id,
  output logic      [3:0]  found_position,
  output logic      [63:0] out_name_high,
  output logic      [63:0] out_name_low,
  output logic      [63:0] out_object_number,
  output logic      [63:0] out_time_value,
  output logic             out_active,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int FILL_W = $clog2(MAX_ENTRIES + 1);

  // names keep their first NAME_BYTES-1 bytes and end at the first zero byte
  function automatic logic [2*VAL_W-1:0] norm_name(logic [2*VAL_W-1:0] raw, int nbytes);
    logic [2*VAL_W-1:0] res;
    logic               ended;
    logic [7:0]         b;
    res   = '0;
    ended = 1'b0;
    for (int i = 0; i < NAME_SPAN; i++) begin
      b = raw[2*VAL_W-1-8*i -: 8];
      if (i >= nbytes - 1 || b == 8'h00) begin
        ended = 1'b1;
      end
      res[2*VAL_W-1-8*i -: 8] = ended ? 8'h00 : b;
    end
    return res;
  endfunction

  cfg_t              cfg;
  logic [FILL_W-1:0] fill_count;
  logic [FILL_W:0]   fill_inc;
  logic              full;
  logic              accept;

  // token chain: link k feeds cell k, link MAX_ENTRIES returns to the control
  logic              link_valid [0:MAX_ENTRIES];
  tok_t              link_tok   [0:MAX_ENTRIES];

  logic [2:0]        cmd_q;      // command of the transfer in flight
  rec_t              req;        // normalized record of the transfer in flight
  rec_t              req_next;
  op_t               op_next;
  tok_t              tok_end;

  logic [1:0]        res_status;
  logic [POS_W-1:0]  res_pos;
  rec_t              res_rec;

  srt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign accept   = start && !busy;
  assign full     = fill_count == FILL_W'(MAX_ENTRIES);
  assign fill_inc = {1'b0, fill_count} + 1'b1;
  assign tok_end  = link_tok[MAX_ENTRIES];

  // incoming record in stored form; its id is the next insert count
  always_comb begin
    {req_next.name_high, req_next.name_low} = norm_name({name_high, name_low}, NAME_BYTES);
    req_next.object_number = object_number;
    req_next.time_value    = time_value;
    req_next.active        = is_active;
    req_next.record_id     = ID_W'(fill_inc);
  end

  // command decode; an insert into a full table walks as a no-op
  always_comb begin
    unique case (command)
      CMD_INSERT:    op_next = full ? OP_NONE : OP_INSERT;
      CMD_FIND_OBJ:  op_next = OP_FIND_OBJ;
      CMD_FIND_NAME: op_next = OP_FIND_NAME;
      CMD_FIND_TIME: op_next = OP_FIND_TIME;
      CMD_READ:      op_next = OP_READ;
      default:       op_next = OP_NONE;
    endcase
  end

  // launch register for the head of the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      link_valid[0] <= 1'b0;
    end else begin
      link_valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q            <= command;
      req              <= req_next;
      link_tok[0].op   <= op_next;
      link_tok[0].flag <= 1'b0;
      link_tok[0].pos  <= POS_W'(position);
      link_tok[0].rec  <= req_next;
    end
  end

  // slot cells
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    srt_cell #(
      .INDEX  (k),
      .FILL_W (FILL_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cfg        (cfg),
      .fill_count (fill_count),
      .in_valid   (link_valid[k]),
      .in_tok     (link_tok[k]),
      .out_valid  (link_valid[k+1]),
      .out_tok    (link_tok[k+1])
    );
  end

  // result from the token that left the last cell
  always_comb begin
    res_status = ST_NOT_FOUND;
    res_pos    = '0;
    res_rec    = '0;
    unique case (cmd_q) inside
      CMD_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_OK;
          res_pos    = tok_end.pos;
          res_rec    = req;
        end
      end
      CMD_FIND_OBJ, CMD_FIND_NAME, CMD_FIND_TIME, CMD_READ: begin
        if (tok_end.flag) begin
          res_status = ST_OK;
          res_pos    = tok_end.pos;
          res_rec    = tok_end.rec;
        end else if (cmd_q == CMD_READ) begin
          res_status = ST_EMPTY;
        end
      end
      default: ;
    endcase
  end

  // control: busy from start until the result strobe, table fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      fill_count <= '0;
    end else begin
      done <= 1'b0;
      if (accept) begin
        busy <= 1'b1;
      end
      if (link_valid[MAX_ENTRIES]) begin
        busy <= 1'b0;
        done <= 1'b1;
        if (cmd_q == CMD_INSERT && !full) begin
          fill_count <= fill_inc[FILL_W-1:0];
        end
      end
    end
  end

  // result registers, held until the next strobe
  always_ff @(posedge clk) begin
    if (link_valid[MAX_ENTRIES]) begin
      status            <= res_status;
      record_id         <= res_rec.record_id;
      found_position    <= res_pos[3:0];
      out_name_high     <= res_rec.name_high;
      out_name_low      <= res_rec.name_low;
      out_object_number <= res_rec.object_number;
      out_time_value    <= res_rec.time_value;
      out_active        <= res_rec.active;
    end
  end

endmodule

`default_nettype wire

FILE: src/srt_checker.sv
// srt_checker: port-level assertions for the sorted record table
// bound to sorted_record_table; uses srt_pkg
`default_nettype none

module srt_checker
  import srt_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [1:0] status,
  input wire logic [4:0] record_id,
  input wire logic [3:0] found_position
);

  // a taken command keeps the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after a command transfer");

  // the strobe comes with busy already low
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // busy only ends with a result
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> done)
    else $error("busy dropped without a result");

  // one cycle per result
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // failed commands carry no record
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> record_id == '0 && found_position == '0)
    else $error("failed command reports a record");

endmodule

bind sorted_record_table srt_checker u_srt_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_sorted_record_table.sv
// tb_sorted_record_table: self-checking bench for the sorted record table
// drives commands and apb register writes, predicts every result in a scoreboard class
// depends on srt_pkg (codes, rec_t) and the sorted_record_table rtl
module tb_sorted_record_table;
  import srt_pkg::*;

  localparam int MAX_ENTRIES    = DEF_MAX_ENTRIES;
  localparam int NAME_BYTES     = DEF_NAME_BYTES;
  localparam int RESULT_LATENCY = MAX_ENTRIES + 1;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int REPORT_CAP     = 100;

  // random part: short early phases spread the few successful inserts over
  // several sort settings, long late phases hammer the (by then full) table
  localparam int RANDOM_ITEMS   = 1930;
  localparam int EARLY_PHASES   = 8;
  localparam int EARLY_ITEMS    = 12;
  localparam int LATE_PHASES    = 10;
  localparam int LATE_ITEMS     = (RANDOM_ITEMS - EARLY_PHASES * EARLY_ITEMS) / LATE_PHASES;

  // codes the package leaves unnamed
  localparam logic [1:0] KEY_SPARE       = 2'd3;  // unused key, orders by timestamp
  localparam logic [2:0] CMD_SPARE_FIRST = CMD_READ + 3'd1;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  localparam logic [1:0] REG_LSB         = 2'b00;  // registers sit on word addresses

  typedef struct {
    logic [2:0]  command;
    logic [63:0] name_high;
    logic [63:0] name_low;
    logic [63:0] object_number;
    logic [63:0] time_value;
    logic        is_active;
    logic [3:0]  position;
  } command_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [4:0]  record_id;
    logic [3:0]  found_position;
    logic [63:0] name_high;
    logic [63:0] name_low;
    logic [63:0] object_number;
    logic [63:0] time_value;
    logic        active;
  } table_result_t;

  // byte i of a 16-byte name, byte 0 is the most significant
  function automatic logic [7:0] name_byte(logic [127:0] n, int i);
    return n[127-8*i -: 8];
  endfunction

  // keep at most NAME_BYTES-1 bytes, cut at the first zero byte
  function automatic logic [127:0] normalize_name(logic [127:0] raw);
    logic [127:0] n;
    logic         ended;
    logic [7:0]   b;
    n = '0;
    ended = 1'b0;
    for (int i = 0; i < 16; i++) begin
      b = name_byte(raw, i);
      if (i >= NAME_BYTES - 1 || ended || b == 8'h00) begin
        ended = 1'b1;
        b = 8'h00;
      end
      n[127-8*i -: 8] = b;
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard: mirrors the table contents and the sort registers
  // ---------------------------------------------------------------------------
  class table_scoreboard;
    rec_t          entries[$];
    table_result_t expected_results[$];
    logic [1:0]    sort_key;
    logic          sort_order;
    logic [4:0]    ids_issued;
    int            error_count;

    function new();
      sort_key    = KEY_TIME;
      sort_order  = 1'b0;
      ids_issued  = '0;
      error_count = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // stored entry sorts strictly after the new record
    function logic sorts_after(rec_t s, logic [127:0] nm, logic [63:0] obj,
                               logic [63:0] tv);
      logic gt;
      logic lt;
      case (sort_key)
        KEY_OBJ: begin
          gt = s.object_number > obj;
          lt = s.object_number < obj;
        end
        KEY_NAME: begin
          gt = {s.name_high, s.name_low} > nm;
          lt = {s.name_high, s.name_low} < nm;
        end
        default: begin
          gt = s.time_value > tv;
          lt = s.time_value < tv;
        end
      endcase
      return sort_order ? lt : gt;
    endfunction

    function table_result_t entry_result(int at);
      table_result_t r;
      r.status         = ST_OK;
      r.record_id      = entries[at].record_id;
      r.found_position = at[3:0];
      r.name_high      = entries[at].name_high;
      r.name_low       = entries[at].name_low;
      r.object_number  = entries[at].object_number;
      r.time_value     = entries[at].time_value;
      r.active         = entries[at].active;
      return r;
    endfunction

    function table_result_t predict_table_result(command_item_t it);
      table_result_t r;
      rec_t          n;
      logic [127:0]  nm;
      int            at;
      logic          hit;
      r = '{default: '0};
      nm = normalize_name({it.name_high, it.name_low});
      case (it.command)
        CMD_INSERT: begin
          if (entries.size() >= MAX_ENTRIES) begin
            r.status = ST_FULL;
          end else begin
            at = entries.size();
            for (int i = 0; i < entries.size(); i++) begin
              if (sorts_after(entries[i], nm, it.object_number, it.time_value)) begin
                at = i;
                break;
              end
            end
            ids_issued++;
            n.name_high     = nm[127:64];
            n.name_low      = nm[63:0];
            n.object_number = it.object_number;
            n.time_value    = it.time_value;
            n.active        = it.is_active;
            n.record_id     = ids_issued;
            entries.insert(at, n);
            r = entry_result(at);
          end
        end
        CMD_FIND_OBJ, CMD_FIND_NAME, CMD_FIND_TIME: begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < entries.size(); i++) begin
            if (it.command == CMD_FIND_OBJ)
              hit = entries[i].object_number == it.object_number;
            else if (it.command == CMD_FIND_NAME)
              hit = {entries[i].name_high, entries[i].name_low} == nm;
            else
              hit = entries[i].time_value == it.time_value;
            if (hit) begin
              r = entry_result(i);
              break;
            end
          end
        end
        CMD_READ: begin
          if (it.position >= entries.size())
            r.status = ST_EMPTY;
          else
            r = entry_result(it.position);
        end
        default: r.status = ST_NOT_FOUND;
      endcase
      return r;
    endfunction

    function void note_command(command_item_t it);
      expected_results.push_back(predict_table_result(it));
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        if (error_count < REPORT_CAP)
          $error("%s: expected %0h, got %0h", field, want, got);
        error_count++;
      end
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (expected_results.size() == 0) begin
        if (error_count < REPORT_CAP)
          $error("result strobe with no command outstanding");
        error_count++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("record_id", want.record_id, got.record_id);
      compare_field("found_position", want.found_position, got.found_position);
      compare_field("out_name_high", want.name_high, got.name_high);
      compare_field("out_name_low", want.name_low, got.name_low);
      compare_field("out_object_number", want.object_number, got.object_number);
      compare_field("out_time_value", want.time_value, got.time_value);
      compare_field("out_active", want.active, got.active);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // block hookup
  // ---------------------------------------------------------------------------
  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  command;
  logic [63:0] name_high;
  logic [63:0] name_low;
  logic [63:0] object_number;
  logic [63:0] time_value;
  logic        is_active;
  logic [3:0]  position;
  logic        done;
  logic [1:0]  status;
  logic [4:0]  record_id;
  logic [3:0]  found_position;
  logic [63:0] out_name_high;
  logic [63:0] out_name_low;
  logic [63:0] out_object_number;
  logic [63:0] out_time_value;
  logic        out_active;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sorted_record_table i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .command          (command),
    .name_high        (name_high),
    .name_low         (name_low),
    .object_number    (object_number),
    .time_value       (time_value),
    .is_active        (is_active),
    .position         (position),
    .done             (done),
    .status           (status),
    .record_id        (record_id),
    .found_position   (found_position),
    .out_name_high    (out_name_high),
    .out_name_low     (out_name_low),
    .out_object_number(out_object_number),
    .out_time_value   (out_time_value),
    .out_active       (out_active),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  table_scoreboard sb;
  int              cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // result side: every strobe is one transfer, the receiver never stalls
  always @(posedge clk) begin
    table_result_t got;
    if (!rst && done) begin
      got.status         = status;
      got.record_id      = record_id;
      got.found_position = found_position;
      got.name_high      = out_name_high;
      got.name_low       = out_name_low;
      got.object_number  = out_object_number;
      got.time_value     = out_time_value;
      got.active         = out_active;
      sb.check_result(got);
    end
  end

  // watchdog: a hung handshake ends the run as a failure
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_sorted_record_table: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // drivers: everything changes on the falling edge
  // ---------------------------------------------------------------------------

  // present one command and hold it until the transfer; start is left high so
  // the caller can chain the next command without a bubble
  task automatic send_command(command_item_t it);
    start         = 1'b1;
    command       = it.command;
    name_high     = it.name_high;
    name_low      = it.name_low;
    object_number = it.object_number;
    time_value    = it.time_value;
    is_active     = it.is_active;
    position      = it.position;
    do @(posedge clk); while (busy);
    sb.note_command(it);
    @(negedge clk);
  endtask

  // sender pause until the table has answered everything
  task automatic wait_drained();
    start = 1'b0;
    while (sb.pending() != 0 || busy) @(negedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // registers only change with the block idle
  task automatic set_sort(logic [1:0] key, logic order);
    wait_drained();
    apb_write({REG_SORT_KEY, REG_LSB}, {30'd0, key});
    apb_write({REG_SORT_ORDER, REG_LSB}, {31'd0, order});
    sb.sort_key   = key;
    sb.sort_order = order;
  endtask

  function automatic command_item_t make_item(logic [2:0] cmd, logic [63:0] nh,
                                              logic [63:0] nl, logic [63:0] obj,
                                              logic [63:0] tv, logic act,
                                              logic [3:0] pos);
    command_item_t it;
    it.command       = cmd;
    it.name_high     = nh;
    it.name_low      = nl;
    it.object_number = obj;
    it.time_value    = tv;
    it.is_active     = act;
    it.position      = pos;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // random content
  // ---------------------------------------------------------------------------

  // scribble over the bytes after the terminator, they must not matter
  function automatic logic [127:0] add_tail_noise(logic [127:0] n);
    int z;
    z = 15;
    for (int i = 0; i < 15; i++)
      if (z == 15 && name_byte(n, i) == 8'h00) z = i;
    for (int i = (z == 15) ? 15 : z + 1; i < 16; i++)
      n[127-8*i -: 8] = 8'($urandom_range(0, 255));
    return n;
  endfunction

  function automatic logic [127:0] random_name();
    logic [127:0] n;
    int           len;
    int           mode;
    n = '0;
    mode = $urandom_range(0, 9);
    case (mode)
      0: n = '0;
      1: n = '1;
      2: n = {$urandom, $urandom, $urandom, $urandom};
      3, 4: begin
        // a stored name, possibly with junk past its end
        if (sb.entries.size() != 0) begin
          len = $urandom_range(0, sb.entries.size() - 1);
          n = {sb.entries[len].name_high, sb.entries[len].name_low};
          if ($urandom_range(0, 1)) n = add_tail_noise(n);
        end else begin
          n = {$urandom, $urandom, $urandom, $urandom};
        end
      end
      5: begin
        // tiny alphabet so name keys tie often
        len = $urandom_range(0, 2);
        for (int i = 0; i < len; i++)
          n[127-8*i -: 8] = $urandom_range(0, 1) ? 8'h41 : 8'h42;
      end
      default: begin
        len = $urandom_range(0, 16);
        for (int i = 0; i < len; i++)
          n[127-8*i -: 8] = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1)) n = add_tail_noise(n);
      end
    endcase
    return n;
  endfunction

  // extremes, tiny values for ties, stored values for hits, else anything
  function automatic logic [63:0] random_value(logic want_time);
    int idx;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return 64'($urandom_range(0, 3));
      4, 5: begin
        if (sb.entries.size() == 0) return {$urandom, $urandom};
        idx = $urandom_range(0, sb.entries.size() - 1);
        return want_time ? sb.entries[idx].time_value : sb.entries[idx].object_number;
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic command_item_t random_item(int insert_pct);
    command_item_t it;
    logic [127:0]  nm;
    int            pick;
    int            idx;
    nm = random_name();
    it = make_item(CMD_INSERT, nm[127:64], nm[63:0], random_value(1'b0),
                   random_value(1'b1), 1'($urandom_range(0, 1)),
                   4'($urandom_range(0, 15)));
    if ($urandom_range(0, 99) < insert_pct) return it;
    pick = $urandom_range(0, 19);
    if (pick < 5)       it.command = CMD_FIND_OBJ;
    else if (pick < 10) it.command = CMD_FIND_NAME;
    else if (pick < 15) it.command = CMD_FIND_TIME;
    else if (pick < 19) it.command = CMD_READ;
    else                it.command = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    // searches aim at a stored record half the time
    if (sb.entries.size() != 0 && $urandom_range(0, 1)) begin
      idx = $urandom_range(0, sb.entries.size() - 1);
      it.object_number = sb.entries[idx].object_number;
      it.time_value    = sb.entries[idx].time_value;
      nm = {sb.entries[idx].name_high, sb.entries[idx].name_low};
      if ($urandom_range(0, 1)) nm = add_tail_noise(nm);
      it.name_high = nm[127:64];
      it.name_low  = nm[63:0];
    end
    return it;
  endfunction

  // one phase: bursts of back-to-back transfers with random gaps between them
  task automatic run_phase(int items, int insert_pct);
    int left;
    int burst;
    left = items;
    while (left > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? 30 : $urandom_range(1, 12);
      for (int k = 0; k < burst && left > 0; k++) begin
        send_command(random_item(insert_pct));
        left--;
      end
      start = 1'b0;
      if ($urandom_range(0, 15) == 0)
        wait_drained();
      else
        repeat ($urandom_range(0, 40)) @(negedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [1:0] key;
    logic       order;
    sb            = new();
    cycle_count   = 0;
    rst           = 1'b1;
    start         = 1'b0;
    command       = CMD_INSERT;
    name_high     = '0;
    name_low      = '0;
    object_number = '0;
    time_value    = '0;
    is_active     = 1'b0;
    position      = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part, reset sort setting (timestamp ascending)
    // empty table: read, search, and the three unknown commands
    send_command(make_item(CMD_READ, '0, '0, '0, '0, 1'b0, 4'd0));
    send_command(make_item(CMD_FIND_OBJ, '0, '0, '0, '0, 1'b0, 4'd0));
    send_command(make_item(CMD_SPARE_FIRST, '1, '1, '1, '1, 1'b1, 4'd15));
    send_command(make_item(CMD_SPARE_FIRST + 3'd1, '0, '0, '0, '0, 1'b0, 4'd0));
    send_command(make_item(CMD_SPARE_LAST, '1, '1, '1, '1, 1'b1, 4'd15));
    // all-ones name loses its last byte; then zero record; then ties on time
    send_command(make_item(CMD_INSERT, '1, '1, '1, '1, 1'b1, 4'd15));
    send_command(make_item(CMD_INSERT, '0, '0, '0, '0, 1'b0, 4'd0));
    send_command(make_item(CMD_INSERT, 64'h4142_00ff_1234_5678, 64'h9abc_def0_0102_0304,
                           '1, '1, 1'b1, 4'd7));
    send_command(make_item(CMD_INSERT, 64'h4100_0000_0000_0000, '0,
                           64'h0123_4567_89ab_cdef, '0, 1'b0, 4'd8));
    // reads by position, filled and empty
    send_command(make_item(CMD_READ, '0, '0, '0, '0, 1'b0, 4'd0));
    send_command(make_item(CMD_READ, '0, '0, '0, '0, 1'b0, 4'd3));
    send_command(make_item(CMD_READ, '0, '0, '0, '0, 1'b0, 4'd4));
    send_command(make_item(CMD_READ, '0, '0, '0, '0, 1'b0, 4'd15));
    // searches: first match in list order, junk after the name terminator, misses
    send_command(make_item(CMD_FIND_OBJ, '0, '0, '1, '0, 1'b0, 4'd0));
    send_command(make_item(CMD_FIND_NAME, 64'h4142_0077_0000_0000, '1, '0, '0, 1'b0, 4'd0));
    send_command(make_item(CMD_FIND_NAME, '1, 64'hffff_ffff_ffff_ff00, '0, '0, 1'b0, 4'd0));
    send_command(make_item(CMD_FIND_NAME, 64'h4300_0000_0000_0000, '0, '0, '0, 1'b0, 4'd0));
    send_command(make_item(CMD_FIND_TIME, '0, '0, '0, '0, 1'b0, 4'd0));
    send_command(make_item(CMD_FIND_TIME, '0, '0, '0, 64'd1, 1'b0, 4'd0));
    send_command(make_item(CMD_FIND_OBJ, '0, '0, 64'h0123_4567_89ab_cdef, '0, 1'b0, 4'd0));

    // early phases walk every sort setting while the table still has room;
    // the table fills up here and full-table inserts follow for the rest
    for (int p = 0; p < EARLY_PHASES; p++) begin
      case (p)
        0: begin key = KEY_TIME;  order = 1'b0; end
        1: begin key = KEY_OBJ;   order = 1'b1; end
        2: begin key = KEY_NAME;  order = 1'b0; end
        3: begin key = KEY_SPARE; order = 1'b1; end
        4: begin key = KEY_NAME;  order = 1'b1; end
        5: begin key = KEY_OBJ;   order = 1'b0; end
        6: begin key = KEY_TIME;  order = 1'b1; end
        default: begin key = KEY_SPARE; order = 1'b0; end
      endcase
      set_sort(key, order);
      run_phase(EARLY_ITEMS, 15);
    end

    for (int p = 0; p < LATE_PHASES; p++) begin
      set_sort(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      run_phase(LATE_ITEMS, 20);
    end

    // drain, then give a straggler strobe time to show up
    wait_drained();
    repeat (2 * RESULT_LATENCY) @(posedge clk);

    if (sb.error_count == 0 && sb.pending() == 0)
      $display("tb_sorted_record_table: done, clean");
    else
      $display("tb_sorted_record_table: done, errors");
    $finish;
  end

endmodule

FILE: files.f
src/srt_pkg.sv
src/srt_regs.sv
src/srt_cell.sv
src/sorted_record_table.sv
src/srt_checker.sv
tb/sv/tb_sorted_record_table.sv
